[src/bbsf_pkg.sv]
// Shared types and op codes for the bounded byte stream FIFO.
// No dependencies; used by bounded_byte_stream_fifo_core and the test files.
package bbsf_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    localparam int CAP_W    = 11;
    localparam int COUNT_W  = 11;
    localparam int TOTAL_W  = 64;
    localparam int LEN_W    = 7;

    typedef struct packed {
        logic [1:0]       op;
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] read_length;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               byte_valid;
        logic               last;
        logic               accepted;
        logic [COUNT_W-1:0] buffered;
        logic [COUNT_W-1:0] space_left;
        logic [TOTAL_W-1:0] total_written;
        logic [TOTAL_W-1:0] total_read;
        logic               stream_ended;
        logic               end_of_stream;
    } out_item_t;

endpackage

[src/bbsf_store.sv]
// Byte store: one write port, one registered read port with write bypass.
// Depends on nothing; instantiated by bounded_byte_stream_fifo_core.
module bbsf_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem_array [DEPTH];
    logic [7:0] rd_q_reg;
    logic [7:0] fwd_data_reg;
    logic       fwd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
        rd_q_reg     <= mem_array[rd_addr];
        fwd_data_reg <= wr_data;
    end

    // same-cycle write to the address being read: return the new byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rd_q_reg;

endmodule

[src/bounded_byte_stream_fifo_core.sv]
// Bounded byte stream FIFO, top level. Uses bbsf_pkg and bbsf_store.
// Holds the control state, totals and the result register.
//
// Byte FIFO with a run-time capacity (cfg register, min'd with DEPTH). A write
// transfer stores one byte if there is room and returns one status result; an
// end transfer sets the sticky input-ended flag; a read transfer asking for L
// bytes returns n = min(L, MAX_READ, buffered) results, one byte each, the
// last one flagged, or one status result when n is zero. Write, end and empty
// read transfers leave the block idle, so such items can stream back to back.
// A read of n bytes occupies the block: the byte store has a single read port
// and hands out one byte per cycle while the result register has room; the
// input is not taken until the last byte is loaded into that register. Every
// result carries the occupancy, free space, 64-bit wrapping totals and the
// ended/eof flags as they stand after that result. The store needs no
// initialization: only held bytes are ever read. The result register
// decouples the two sides, so a new transfer is taken while the previous
// result still waits, as long as that result is consumed in the same cycle.
module bounded_byte_stream_fifo_core #(
    parameter int DEPTH    = 1024,
    parameter int MAX_READ = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [bbsf_pkg::CAP_W-1:0]   cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  bbsf_pkg::in_item_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output bbsf_pkg::out_item_t          m_data
);

    // widths
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;      // store address
    localparam int CW = $clog2(DEPTH + 1);                     // held count
    localparam int SW = CW + 1;                                // head + count
    localparam int LW = (CW > bbsf_pkg::CAP_W) ? CW : bbsf_pkg::CAP_W; // compares
    localparam int RW = $clog2(MAX_READ + 1);                  // bytes left to send

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    // state
    logic                         state_reg, state_next;
    logic [PW-1:0]                head_reg, head_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [bbsf_pkg::TOTAL_W-1:0] wtot_reg, wtot_next;
    logic [bbsf_pkg::TOTAL_W-1:0] rtot_reg, rtot_next;
    logic                         ended_reg, ended_next;
    logic [RW-1:0]                rem_reg, rem_next;
    logic [bbsf_pkg::CAP_W-1:0]   cap_reg;

    // result register
    logic                         m_valid_reg;
    bbsf_pkg::out_item_t          m_data_reg, m_data_next;
    logic                         load_out;

    // store interface
    logic                         st_we;
    logic [PW-1:0]                st_waddr;
    logic [7:0]                   st_rdata;

    // datapath helpers
    logic                         out_free;
    logic [LW-1:0]                eff_cap;
    logic [LW-1:0]                count_ext;
    logic [LW-1:0]                len_clamp;
    logic [LW-1:0]                n_ext;
    logic [SW-1:0]                tail_sum;
    logic [PW-1:0]                tail_ptr;
    logic [PW:0]                  head_inc;
    logic [PW-1:0]                head_adv;

    // status fields of a result, computed from the post-update state
    function automatic bbsf_pkg::out_item_t make_result(
        input logic [7:0]                  b,
        input logic                        valid,
        input logic                        last,
        input logic                        acc,
        input logic [LW-1:0]               cnt,
        input logic [LW-1:0]               cap,
        input logic [bbsf_pkg::TOTAL_W-1:0] wtot,
        input logic [bbsf_pkg::TOTAL_W-1:0] rtot,
        input logic                        ended
    );
        bbsf_pkg::out_item_t r;
        logic [LW-1:0]       space;
        space           = (cnt < cap) ? (cap - cnt) : '0;
        r.out_byte      = valid ? b : 8'd0;
        r.byte_valid    = valid;
        r.last          = last;
        r.accepted      = acc;
        r.buffered      = bbsf_pkg::COUNT_W'(cnt);
        r.space_left    = bbsf_pkg::COUNT_W'(space);
        r.total_written = wtot;
        r.total_read    = rtot;
        r.stream_ended  = ended;
        r.end_of_stream = ended && (cnt == '0);
        return r;
    endfunction

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign eff_cap   = (LW'(cap_reg) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(cap_reg);
    assign count_ext = LW'(count_reg);

    // tail = (head + count) mod DEPTH; the sum stays below 2*DEPTH
    assign tail_sum  = SW'(head_reg) + SW'(count_reg);
    assign tail_ptr  = (tail_sum >= SW'(DEPTH)) ? PW'(tail_sum - SW'(DEPTH))
                                                : PW'(tail_sum);
    assign head_inc  = (PW+1)'(head_reg) + (PW+1)'(1);
    assign head_adv  = (head_inc >= (PW+1)'(DEPTH)) ? '0 : PW'(head_inc);

    // requested length clamped to MAX_READ and to what is held
    assign len_clamp = (LW'(s_data.read_length) > LW'(MAX_READ)) ? LW'(MAX_READ)
                                                                 : LW'(s_data.read_length);
    assign n_ext     = (len_clamp < count_ext) ? len_clamp : count_ext;

    always_comb begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        wtot_next   = wtot_reg;
        rtot_next   = rtot_reg;
        ended_next  = ended_reg;
        rem_next    = rem_reg;
        st_we       = 1'b0;
        st_waddr    = tail_ptr;
        load_out    = 1'b0;
        m_data_next = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    load_out = 1'b1;
                    unique case (s_data.op)
                        bbsf_pkg::OP_WRITE: begin
                            if (count_ext < eff_cap) begin
                                st_we      = 1'b1;
                                count_next = count_reg + CW'(1);
                                wtot_next  = wtot_reg + 64'd1;
                                m_data_next = make_result(8'd0, 1'b0, 1'b1, 1'b1,
                                    count_ext + LW'(1), eff_cap, wtot_next,
                                    rtot_reg, ended_reg);
                            end else begin
                                m_data_next = make_result(8'd0, 1'b0, 1'b1, 1'b0,
                                    count_ext, eff_cap, wtot_reg, rtot_reg,
                                    ended_reg);
                            end
                        end
                        bbsf_pkg::OP_READ: begin
                            if (n_ext == '0) begin
                                m_data_next = make_result(8'd0, 1'b0, 1'b1, 1'b0,
                                    count_ext, eff_cap, wtot_reg, rtot_reg,
                                    ended_reg);
                            end else begin
                                // first byte goes out in the accepting cycle
                                head_next  = head_adv;
                                count_next = count_reg - CW'(1);
                                rtot_next  = rtot_reg + 64'd1;
                                m_data_next = make_result(st_rdata, 1'b1,
                                    n_ext == LW'(1), 1'b0, count_ext - LW'(1),
                                    eff_cap, wtot_reg, rtot_next, ended_reg);
                                if (n_ext != LW'(1)) begin
                                    state_next = ST_READ;
                                    rem_next   = RW'(n_ext - LW'(1));
                                end
                            end
                        end
                        bbsf_pkg::OP_END: begin
                            ended_next  = 1'b1;
                            m_data_next = make_result(8'd0, 1'b0, 1'b1, 1'b0,
                                count_ext, eff_cap, wtot_reg, rtot_reg, 1'b1);
                        end
                        default: begin
                            m_data_next = make_result(8'd0, 1'b0, 1'b1, 1'b0,
                                count_ext, eff_cap, wtot_reg, rtot_reg, ended_reg);
                        end
                    endcase
                end
            end
            ST_READ: begin
                // one byte per cycle while the result register has room
                if (out_free) begin
                    load_out   = 1'b1;
                    head_next  = head_adv;
                    count_next = count_reg - CW'(1);
                    rtot_next  = rtot_reg + 64'd1;
                    rem_next   = rem_reg - RW'(1);
                    m_data_next = make_result(st_rdata, 1'b1, rem_reg == RW'(1), 1'b0,
                        count_ext - LW'(1), eff_cap, wtot_reg, rtot_next, ended_reg);
                    if (rem_reg == RW'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // read address follows the next head so the store output is always the
    // byte at the current head
    bbsf_store #(
        .DEPTH (DEPTH),
        .AW    (PW)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (s_data.data_byte),
        .rd_addr (head_next),
        .rd_data (st_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            wtot_reg    <= '0;
            rtot_reg    <= '0;
            ended_reg   <= 1'b0;
            rem_reg     <= '0;
            cap_reg     <= bbsf_pkg::CAP_W'(1024);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            wtot_reg  <= wtot_next;
            rtot_reg  <= rtot_next;
            ended_reg <= ended_next;
            rem_reg   <= rem_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

[test/bbsf_stream_checker.sv]
// Checker for the bounded byte stream FIFO: predicts every result of each input
// transfer and compares the result channel against it. Depends on bbsf_pkg.
`timescale 1ns / 100ps

module bbsf_stream_checker #(
    parameter int DEPTH      = 1024,
    parameter int MAX_READ   = 64,
    parameter int REPORT_MAX = 10
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [bbsf_pkg::CAP_W-1:0] cfg_wr_data,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  bbsf_pkg::in_item_t         s_data,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  bbsf_pkg::out_item_t        m_data,
    output int unsigned                fail_count,
    output int unsigned                pending,
    output int unsigned                results_seen
);

    localparam logic [bbsf_pkg::CAP_W-1:0] CAP_AT_RESET = 11'd1024;

    logic [bbsf_pkg::CAP_W-1:0]   capacity;
    logic [7:0]                   held_bytes[$];
    bbsf_pkg::out_item_t          expected_results[$];
    logic [bbsf_pkg::TOTAL_W-1:0] written_total;
    logic [bbsf_pkg::TOTAL_W-1:0] read_total;
    logic                         ended;

    function automatic int unsigned usable_capacity();
        return (capacity > DEPTH) ? DEPTH : 32'(capacity);
    endfunction

    // status fields as they stand after the current step
    function automatic bbsf_pkg::out_item_t status_now(input logic [7:0] b,
                                                       input logic valid,
                                                       input logic last,
                                                       input logic stored);
        bbsf_pkg::out_item_t r;
        int unsigned         held;
        int unsigned         limit;
        int unsigned         space;
        held  = held_bytes.size();
        limit = usable_capacity();
        space = (held < limit) ? (limit - held) : 0;
        r.out_byte      = b;
        r.byte_valid    = valid;
        r.last          = last;
        r.accepted      = stored;
        r.buffered      = bbsf_pkg::COUNT_W'(held);
        r.space_left    = bbsf_pkg::COUNT_W'(space);
        r.total_written = written_total;
        r.total_read    = read_total;
        r.stream_ended  = ended;
        r.end_of_stream = ended && (held == 0);
        return r;
    endfunction

    task automatic predict_results(input bbsf_pkg::in_item_t item);
        int unsigned n;
        int unsigned k;
        logic        stored;
        logic [7:0]  b;
        unique case (item.op)
            bbsf_pkg::OP_WRITE: begin
                stored = (held_bytes.size() < usable_capacity());
                if (stored) begin
                    held_bytes.push_back(item.data_byte);
                    written_total++;
                end
                expected_results.push_back(status_now(8'd0, 1'b0, 1'b1, stored));
            end
            bbsf_pkg::OP_READ: begin
                n = 32'(item.read_length);
                if (n > MAX_READ) n = MAX_READ;
                if (n > held_bytes.size()) n = held_bytes.size();
                if (n == 0) begin
                    expected_results.push_back(status_now(8'd0, 1'b0, 1'b1, 1'b0));
                end else begin
                    for (k = 0; k < n; k++) begin
                        b = held_bytes.pop_front();
                        read_total++;
                        expected_results.push_back(status_now(b, 1'b1, (k + 1 == n), 1'b0));
                    end
                end
            end
            bbsf_pkg::OP_END: begin
                ended = 1'b1;
                expected_results.push_back(status_now(8'd0, 1'b0, 1'b1, 1'b0));
            end
            default: begin
                expected_results.push_back(status_now(8'd0, 1'b0, 1'b1, 1'b0));
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("result %0d: %s expected %0h, got %0h", results_seen, name, want, got);
        end
    endtask

    task automatic compare_result(input bbsf_pkg::out_item_t got);
        bbsf_pkg::out_item_t want;
        if (expected_results.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("result %0d: unexpected transfer %h", results_seen, got);
        end else begin
            want = expected_results.pop_front();
            check_field("out_byte",      64'(want.out_byte),      64'(got.out_byte));
            check_field("byte_valid",    64'(want.byte_valid),    64'(got.byte_valid));
            check_field("last",          64'(want.last),          64'(got.last));
            check_field("accepted",      64'(want.accepted),      64'(got.accepted));
            check_field("buffered",      64'(want.buffered),      64'(got.buffered));
            check_field("space_left",    64'(want.space_left),    64'(got.space_left));
            check_field("total_written", want.total_written,      got.total_written);
            check_field("total_read",    want.total_read,         got.total_read);
            check_field("stream_ended",  64'(want.stream_ended),  64'(got.stream_ended));
            check_field("end_of_stream", 64'(want.end_of_stream), 64'(got.end_of_stream));
        end
    endtask

    // result first: a result at this edge always belongs to an older input transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            capacity      = CAP_AT_RESET;
            written_total = '0;
            read_total    = '0;
            ended         = 1'b0;
            fail_count    = 0;
            results_seen  = 0;
            held_bytes.delete();
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                compare_result(m_data);
            end
            if (s_valid && s_ready) predict_results(s_data);
            if (cfg_wr_en) capacity = cfg_wr_data;
        end
        pending = expected_results.size();
    end

endmodule

[test/tb_top.sv]
// Top of the bounded byte stream FIFO testbench: clock, reset, stimulus, back-pressure
// and verdict. Depends on bbsf_pkg, bounded_byte_stream_fifo_core and bbsf_stream_checker.
`timescale 1ns / 100ps

module tb_top;

    localparam int DEPTH          = 1024;
    localparam int MAX_READ       = 64;
    // op code 3 has no meaning in the block; it must still give one status result
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam logic [bbsf_pkg::CAP_W-1:0] CAP_ABOVE_DEPTH = 11'd2047;
    // idle cycles before a capacity write and at the end; the block is idle by then
    localparam int SETTLE_CYCLES  = 10;
    // long receiver hold-off, well under the watchdog limit
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic [bbsf_pkg::CAP_W-1:0] cfg_wr_data;
    logic                       s_valid;
    logic                       s_ready;
    bbsf_pkg::in_item_t         s_data;
    logic                       m_valid;
    logic                       m_ready;
    bbsf_pkg::out_item_t        m_data;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned results_seen;
    int unsigned items_sent;

    // percentages for the current phase; read by the sender and the receiver
    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;
    logic        hold_request;

    bounded_byte_stream_fifo_core #(
        .DEPTH    (DEPTH),
        .MAX_READ (MAX_READ)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    bbsf_stream_checker #(
        .DEPTH    (DEPTH),
        .MAX_READ (MAX_READ)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: random stalls at the phase's rate. A hold-off request keeps ready low
    // for HOLD_CYCLES so the result register backs up and the block stops taking input.
    initial begin
        bit hold_taken;
        hold_taken = 1'b0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: any transfer, config write or reset cycle restarts the count.
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en || !aresetn)
                quiet = 0;
            else
                quiet++;
        end
        $display("no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("bounded_byte_stream_fifo_core test failed");
        $finish;
    end

    task automatic set_idling(input int unsigned gap_pct, input int unsigned stall_pct);
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
    endtask

    // One input transfer. Valid goes up on a falling edge after any random gap and
    // stays up, payload fixed, until the rising edge where ready is seen high.
    // The next call (or drain) moves valid on the very next falling edge.
    task automatic send_item(input bbsf_pkg::in_item_t item);
        @(negedge aclk);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_fields(input logic [1:0] op, input logic [7:0] data_byte,
                               input logic [bbsf_pkg::LEN_W-1:0] read_length);
        bbsf_pkg::in_item_t item;
        item.op          = op;
        item.data_byte   = data_byte;
        item.read_length = read_length;
        send_item(item);
    endtask

    // Sender pause: drop valid and wait until every predicted result has been seen.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Capacity writes happen only with the block drained and idle.
    task automatic write_capacity(input logic [bbsf_pkg::CAP_W-1:0] value);
        drain_results();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Random traffic in alternating bursts: write-heavy bursts push the FIFO toward
    // its capacity, read-heavy bursts drain it, so both full and empty get hit.
    task automatic run_random(input int unsigned count);
        bbsf_pkg::in_item_t item;
        int unsigned        pick;
        int unsigned        write_pct;
        int unsigned        burst_left;
        bit                 filling;
        burst_left = 0;
        filling    = 1'b0;
        repeat (count) begin
            if (burst_left == 0) begin
                filling    = !filling;
                burst_left = $urandom_range(6, 40);
            end
            burst_left--;
            write_pct        = filling ? 75 : 25;
            pick             = $urandom_range(99);
            item.data_byte   = 8'($urandom_range(255));
            // mostly sensible lengths, some zero or beyond the read limit
            item.read_length = ($urandom_range(99) < 80)
                             ? bbsf_pkg::LEN_W'($urandom_range(1, MAX_READ))
                             : bbsf_pkg::LEN_W'($urandom_range(127));
            if (pick < write_pct)
                item.op = bbsf_pkg::OP_WRITE;
            else if (pick < 92)
                item.op = bbsf_pkg::OP_READ;
            else if (pick < 96)
                item.op = bbsf_pkg::OP_END;
            else
                item.op = OP_SPARE;
            send_item(item);
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_data       = '0;
        items_sent   = 0;
        hold_request = 1'b0;
        set_idling(0, 0);
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // ---- directed part, reset capacity ----
        // reads on an empty FIFO, with and without a length, and the unused op
        send_fields(bbsf_pkg::OP_READ,  8'h00, 7'd0);
        send_fields(bbsf_pkg::OP_READ,  8'h00, 7'd5);
        send_fields(OP_SPARE,           8'hFF, 7'h7F);
        // byte extremes and alternating bit patterns
        send_fields(bbsf_pkg::OP_WRITE, 8'h00, 7'd0);
        send_fields(bbsf_pkg::OP_WRITE, 8'hFF, 7'd0);
        send_fields(bbsf_pkg::OP_WRITE, 8'hA5, 7'd0);
        send_fields(bbsf_pkg::OP_WRITE, 8'h5A, 7'd0);
        send_fields(bbsf_pkg::OP_WRITE, 8'h01, 7'd0);
        send_fields(bbsf_pkg::OP_WRITE, 8'h80, 7'd0);
        // zero-length read with data held, then a short read
        send_fields(bbsf_pkg::OP_READ,  8'h00, 7'd0);
        send_fields(bbsf_pkg::OP_READ,  8'h00, 7'd2);
        // end of input, a write after it still lands, then drain to end of stream
        send_fields(bbsf_pkg::OP_END,   8'h00, 7'd0);
        send_fields(bbsf_pkg::OP_WRITE, 8'h7E, 7'd0);
        send_fields(bbsf_pkg::OP_READ,  8'h00, 7'h7F);
        send_fields(bbsf_pkg::OP_END,   8'h00, 7'd0);
        send_fields(bbsf_pkg::OP_READ,  8'h00, 7'd1);

        // capacity zero: every write refused
        write_capacity(11'd0);
        send_fields(bbsf_pkg::OP_WRITE, 8'h33, 7'd0);
        send_fields(bbsf_pkg::OP_READ,  8'h00, 7'd1);

        // capacity above the store depth acts as full depth
        write_capacity(CAP_ABOVE_DEPTH);
        send_fields(bbsf_pkg::OP_WRITE, 8'hC3, 7'd0);
        send_fields(bbsf_pkg::OP_WRITE, 8'h3C, 7'd0);
        send_fields(bbsf_pkg::OP_WRITE, 8'h99, 7'd0);
        send_fields(bbsf_pkg::OP_WRITE, 8'h66, 7'd0);

        // capacity lowered under the held count: nothing lost, writes refused,
        // space reads zero until reads bring the count back under capacity
        write_capacity(11'd2);
        send_fields(bbsf_pkg::OP_WRITE, 8'h11, 7'd0);
        send_fields(bbsf_pkg::OP_READ,  8'h00, 7'd3);
        send_fields(bbsf_pkg::OP_WRITE, 8'h22, 7'd0);
        send_fields(bbsf_pkg::OP_WRITE, 8'h44, 7'd0);

        // ---- random phases: capacity and idling change together ----
        write_capacity(11'd1);
        set_idling(0, 0);
        run_random(60);

        write_capacity(11'd16);
        set_idling(74, 0);
        run_random(80);

        write_capacity(11'd100);
        set_idling(0, 74);
        run_random(80);

        write_capacity(11'd37);
        set_idling(32, 32);
        run_random(80);

        // receiver holds off while the sender keeps offering: the block backs up
        write_capacity(11'd64);
        set_idling(0, 0);
        hold_request = 1'b1;
        run_random(50);
        // sender waits for every outstanding result before going on
        drain_results();

        // a length over the read limit is clamped to it
        write_capacity(CAP_ABOVE_DEPTH);
        repeat (MAX_READ + 6) send_fields(bbsf_pkg::OP_WRITE, 8'($urandom_range(255)), 7'd0);
        send_fields(bbsf_pkg::OP_READ, 8'h00, 7'h7F);
        send_fields(bbsf_pkg::OP_READ, 8'h00, 7'h7F);

        // back to the reset value, written explicitly
        write_capacity(11'd1024);
        set_idling(32, 32);
        run_random(50);

        drain_results();
        $display("Covered %0d input transfers and %0d result transfers.", items_sent,
                 results_seen);
        $display("Capacities 0 to above depth, clamped reads, hold-off and random gaps.");
        if (fail_count == 0 && pending == 0) begin
            $display("bounded_byte_stream_fifo_core test passed");
        end else begin
            if (pending != 0)
                $display("%0d expected results never arrived", pending);
            $display("bounded_byte_stream_fifo_core test failed");
        end
        $finish;
    end

endmodule
